>>> hw/rtl/pvrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvrt_pkg
// Shared types, widths and operation codes of the path-vector route table.
// ----------------------------------------------------------------------------
package pvrt_pkg;

    localparam int ID_W     = 4;
    localparam int COST_W   = 10;
    localparam int LEN_W    = 5;
    localparam int PATH_W   = 64;
    localparam int OP_W     = 3;
    localparam int COUNT_W  = 5;
    localparam int PATH_IDS = PATH_W / ID_W;

    localparam int DEF_MAX_ROUTES    = 16;
    localparam int DEF_COST_INFINITY = 1023;

    // input tdata: op, dest_id, route_cost, adv_len, adv_path, sender,
    // link_cost, read_index
    localparam int IN_DATA_W  = 104;
    // output tdata: flags, count, read entry
    localparam int OUT_DATA_W = 96;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_NB = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE = 3'd2;
    localparam logic [OP_W-1:0] OP_DEATH  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] cost;
        logic [LEN_W-1:0]  plen;
        logic [PATH_W-1:0] path;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // saturate a cost at the infinity value
    function automatic logic [COST_W-1:0] clamp_cost(input logic [COST_W:0] c,
                                                     input logic [COST_W-1:0] inf);
        clamp_cost = (c > {1'b0, inf}) ? inf : c[COST_W-1:0];
    endfunction

endpackage

>>> hw/rtl/pvrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/path_vector_route_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_vector_route_table
// Route table with clear, add-neighbor, route update, neighbor death and read.
// ----------------------------------------------------------------------------
// channel   direction  signals                            content
// s_axis    in         i_s_axis_tvalid/tready/tdata/tlast  one operation
// m_axis    out        o_m_axis_tvalid/tready/tdata        one result
// cfg       in         i_cfg_valid/o_cfg_ready/i_cfg_data  my_id register
//
// Clear, add-neighbor and unused codes pass through PREP to DONE; a read
// with a valid index adds RDO. Update and neighbor death scan the table
// through one RAM read port, RD and EV per valid entry, then FIN.
// Synchronous active-low reset empties the table; no clearing pass.
// A stalled result is held while the next transaction is taken in.
// ----------------------------------------------------------------------------
module path_vector_route_table #(
    parameter int MAX_ROUTES    = pvrt_pkg::DEF_MAX_ROUTES,
    parameter int COST_INFINITY = pvrt_pkg::DEF_COST_INFINITY
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // op, dest_id, route_cost, adv_len, adv_path, sender, link_cost,
    // read_index
    input  logic [pvrt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // last_entry
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // entry_changed, packet_changed, dropped, route_count, index_valid,
    // out_dest, out_hop, out_cost, out_plen, out_path
    output logic [pvrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pvrt_pkg::ID_W-1:0]       i_cfg_data
);
    import pvrt_pkg::*;

    localparam int AW = $clog2(MAX_ROUTES);
    localparam logic [COST_W-1:0]  INF   = COST_W'(COST_INFINITY);
    localparam logic [COUNT_W-1:0] MAXC  = COUNT_W'(MAX_ROUTES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_RDO  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [ID_W-1:0]     r_my_id;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_acc, n_acc;
    logic [COUNT_W-1:0]  r_idx, n_idx;

    // captured item
    logic [OP_W-1:0]     r_op;
    logic [ID_W-1:0]     r_dest, r_sender, r_ridx;
    logic [COST_W-1:0]   r_rcost, r_lcost;
    logic [LEN_W-1:0]    r_alen;
    logic [PATH_W-1:0]   r_apath;
    logic                r_last;

    // derived per item
    logic [COST_W-1:0]   r_sum, n_sum;
    logic                r_loop, n_loop;
    logic [PATH_W-1:0]   r_newpath, n_newpath;
    logic                r_found, n_found;

    // working result
    logic                r_chg, n_chg, r_drop, n_drop, r_pkt, n_pkt, r_rdv, n_rdv;
    t_entry              r_rde, n_rde;

    // output register
    logic                r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    t_entry              wdata, rdata;
    logic [ENTRY_W-1:0]  rdata_raw;
    logic                path_full;
    logic [LEN_W-1:0]    newlen;
    logic                s_acc, o_free;

    assign s_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign o_free    = !r_ovalid || i_m_axis_tready;
    assign path_full = (r_alen >= LEN_W'(PATH_IDS));
    assign newlen    = r_alen + LEN_W'(1);
    assign rdata     = t_entry'(rdata_raw);

    pvrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ROUTES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    // item capture and config register
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op     <= i_s_axis_tdata[2:0];
            r_dest   <= i_s_axis_tdata[6:3];
            r_rcost  <= i_s_axis_tdata[16:7];
            r_alen   <= i_s_axis_tdata[21:17];
            r_apath  <= i_s_axis_tdata[85:22];
            r_sender <= i_s_axis_tdata[89:86];
            r_lcost  <= i_s_axis_tdata[99:90];
            r_ridx   <= i_s_axis_tdata[103:100];
            r_last   <= i_s_axis_tlast;
        end
        if (!i_rst_n) begin
            r_my_id <= '0;
        end else if (i_cfg_valid) begin
            r_my_id <= i_cfg_data;
        end
    end

    // loop check, new path and saturated sum
    always_comb begin
        n_loop    = 1'b0;
        n_newpath = '0;
        for (int j = 0; j < PATH_IDS; j++) begin
            if (LEN_W'(j) < r_alen) begin
                if (r_apath[j*ID_W +: ID_W] == r_my_id) begin
                    n_loop = 1'b1;
                end
                if (j < PATH_IDS - 1) begin
                    n_newpath[(j+1)*ID_W +: ID_W] = r_apath[j*ID_W +: ID_W];
                end
            end
        end
        n_newpath[ID_W-1:0] = r_my_id;
        n_sum = clamp_cost({1'b0, clamp_cost({1'b0, r_rcost}, INF)}
                           + {1'b0, clamp_cost({1'b0, r_lcost}, INF)}, INF);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_found = r_found;
        n_chg   = r_chg;
        n_drop  = r_drop;
        n_pkt   = r_pkt;
        n_rdv   = r_rdv;
        n_rde   = r_rde;
        we      = 1'b0;
        waddr   = r_idx[AW-1:0];
        wdata   = rdata;
        raddr   = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_state = S_PREP;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_chg   = 1'b0;
                    n_drop  = 1'b0;
                    n_pkt   = 1'b0;
                    n_rdv   = 1'b0;
                    n_rde   = '0;
                end
            end
            S_PREP: begin
                n_state = S_DONE;
                unique case (r_op) inside
                    OP_CLEAR: begin
                        we      = 1'b1;
                        waddr   = '0;
                        wdata   = '{r_my_id, r_my_id, '0, LEN_W'(1),
                                    PATH_W'(r_my_id)};
                        n_count = COUNT_W'(1);
                        n_acc   = 1'b0;
                        n_chg   = 1'b1;
                    end
                    OP_ADD_NB: begin
                        if (r_count >= MAXC) begin
                            n_drop = 1'b1;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            wdata   = '{r_dest, r_dest,
                                        clamp_cost({1'b0, r_rcost}, INF),
                                        LEN_W'(2),
                                        PATH_W'({r_dest, r_my_id})};
                            n_count = r_count + COUNT_W'(1);
                            n_chg   = 1'b1;
                        end
                    end
                    OP_UPDATE, OP_DEATH: begin
                        n_state = (r_count == '0) ? S_FIN : S_RD;
                    end
                    OP_READ: begin
                        raddr = r_ridx[AW-1:0];
                        if ({1'b0, r_ridx} < r_count) begin
                            n_rdv   = 1'b1;
                            n_state = S_RDO;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                // examine one table entry
                if (r_op == OP_UPDATE) begin
                    if (rdata.dest == r_dest) begin
                        n_found = 1'b1;
                        if (r_sum < rdata.cost && !r_loop) begin
                            if (path_full) begin
                                n_drop = 1'b1;
                            end else begin
                                we    = 1'b1;
                                wdata = '{r_dest, r_sender, r_sum, newlen, r_newpath};
                                n_chg = 1'b1;
                            end
                        end else if (rdata.hop == r_sender && r_sum > rdata.cost) begin
                            we         = 1'b1;
                            wdata.cost = r_sum;
                            n_chg      = 1'b1;
                        end
                    end
                end else if (rdata.hop == r_dest && rdata.cost != INF) begin
                    we         = 1'b1;
                    wdata.cost = INF;
                    n_chg      = 1'b1;
                end
                n_idx   = r_idx + COUNT_W'(1);
                n_state = (n_idx < r_count) ? S_RD : S_FIN;
            end
            S_FIN: begin
                n_state = S_DONE;
                if (r_op == OP_UPDATE) begin
                    if (!r_found) begin
                        if (path_full || r_count >= MAXC) begin
                            n_drop = 1'b1;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[AW-1:0];
                            wdata   = '{r_dest, r_sender, r_sum, newlen, r_newpath};
                            n_count = r_count + COUNT_W'(1);
                            n_chg   = 1'b1;
                        end
                    end
                    if (r_last) begin
                        n_pkt = r_acc | n_chg;
                        n_acc = 1'b0;
                    end else begin
                        n_acc = r_acc | n_chg;
                    end
                end
            end
            S_RDO: begin
                n_rde   = rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_acc    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_acc   <= n_acc;
            if (r_state == S_DONE && o_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_found <= n_found;
        r_chg   <= n_chg;
        r_drop  <= n_drop;
        r_pkt   <= n_pkt;
        r_rdv   <= n_rdv;
        r_rde   <= n_rde;
        if (r_state == S_PREP) begin
            r_sum     <= n_sum;
            r_loop    <= n_loop;
            r_newpath <= n_newpath;
        end
        if (r_state == S_DONE && o_free) begin
            r_odata <= {r_rde.path, r_rde.plen, r_rde.cost, r_rde.hop,
                        r_rde.dest, r_rdv, r_count, r_drop, r_pkt, r_chg};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_cfg_ready     = 1'b1;

    // table never holds more routes than it has room for
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC)
        else $error("route count above table size");

    // every scanned entry lies below the route count
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EV) |-> (r_idx < r_count))
        else $error("scan index past route count");

    // an accepted item leaves idle at once
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state == S_PREP))
        else $error("accepted item not started");

    // a clear leaves exactly the self route
    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP && r_op == OP_CLEAR) |=> (r_count == COUNT_W'(1)))
        else $error("clear did not leave one route");
endmodule
